[sv/line_follow_pid_steering_macros.svh]
// Assertion macros shared by the line follower steering checker.
`ifndef LINE_FOLLOW_PID_STEERING_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_MACROS_SVH

// Same-cycle implication, sampled on aclk, quiet while reset is applied.
`define LFPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while reset is applied.
`define LFPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after reset is seen low.
`define LFPS_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

[sv/lfps_pkg.sv]
// Package with constants, register indexes and helper functions of the steering block.
`default_nettype none

package lfps_pkg;

    localparam int GAIN_W  = 24;
    localparam int SPEED_W = 8;
    localparam int ERR_W   = 4;
    localparam int INTEG_W = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd3;

    // Command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]         KP_RESET   = 24'd196608;
    localparam logic [GAIN_W-1:0]         KI_RESET   = 24'd524;
    localparam logic [GAIN_W-1:0]         KD_RESET   = 24'd393216;
    localparam logic signed [SPEED_W-1:0] BASE_RESET = 8'sd40;

    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 8'sd80;
    localparam logic signed [INTEG_W:0]   INTEG_MAX   = 17'sd32767;
    localparam logic signed [INTEG_W:0]   INTEG_MIN   = -17'sd32767;

    // Sensor pattern to line position error. All sensors high keeps the
    // sign of the previous error at full magnitude; unknown patterns keep
    // the previous error.
    function automatic logic signed [ERR_W-1:0] decode_error(
        input logic [3:0]              bits,
        input logic signed [ERR_W-1:0] prev
    );
        logic signed [ERR_W-1:0] e;
        e = prev;
        case (bits)
            4'd15:   e = prev[ERR_W-1] ? -4'sd7 : 4'sd7;
            4'd14:   e = 4'sd5;
            4'd13:   e = 4'sd5;
            4'd12:   e = 4'sd3;
            4'd8:    e = 4'sd1;
            4'd9:    e = 4'sd0;
            4'd1:    e = -4'sd1;
            4'd3:    e = -4'sd3;
            4'd7:    e = -4'sd5;
            4'd11:   e = -4'sd5;
            default: e = prev;
        endcase
        return e;
    endfunction

    // Clamp a 9-bit signed speed sum to the motor range.
    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W:0] v
    );
        logic signed [SPEED_W:0] hi;
        logic signed [SPEED_W:0] lo;
        logic signed [SPEED_W-1:0] r;
        hi = {SPEED_LIMIT[SPEED_W-1], SPEED_LIMIT};
        lo = -hi;
        if (v > hi) begin
            r = SPEED_LIMIT;
        end else if (v < lo) begin
            r = -SPEED_LIMIT;
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/line_follow_pid_steering.sv]
// Top level of the line follower PID steering block.
`default_nettype none

// Line follower PID steering. Each input beat carries a command and four
// infrared sensor levels; each one yields exactly one result beat with the
// left and right motor setpoints, the clamped steering drive and the decoded
// position error. A sample command decodes the sensors, advances the
// saturating integral and takes the derivative against the previous error;
// a clear command zeroes the controller state and returns a zero drive. The
// controller state is updated in the cycle a beat is accepted, so a new beat
// can be taken on every clock while the first stage is ready. The decode is
// registered at the accepting edge, then come the multiply, the sum, the
// truncate and clamp, and the speed mix, one register each, and the last
// presents the result beat. The pipeline carries one beat per cycle as long
// as results are taken; while a result waits, up to four further beats can
// enter until every stage is full. The gains and the base speed are written
// on the configuration port, which is always ready; they are meant to change
// only while no beat is in flight.
module line_follow_pid_steering (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Configuration write channel.
    input  wire logic                                   cfg_valid,
    output      logic                                   cfg_ready,
    input  wire logic [lfps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [lfps_pkg::GAIN_W-1:0]            cfg_data,
    // Sample channel.
    input  wire logic                                   s_valid,
    output      logic                                   s_ready,
    input  wire logic                                   s_cmd,
    input  wire logic [3:0]                             s_sensor_bits,
    // Result channel.
    output      logic                                   m_valid,
    input  wire logic                                   m_ready,
    output      logic signed [lfps_pkg::SPEED_W-1:0]    m_left_speed,
    output      logic signed [lfps_pkg::SPEED_W-1:0]    m_right_speed,
    output      logic signed [lfps_pkg::SPEED_W-1:0]    m_drive,
    output      logic signed [lfps_pkg::ERR_W-1:0]      m_position_error
);

    localparam int ERR_W   = lfps_pkg::ERR_W;
    localparam int INTEG_W = lfps_pkg::INTEG_W;
    localparam int GAIN_W  = lfps_pkg::GAIN_W;
    localparam int SPEED_W = lfps_pkg::SPEED_W;
    localparam int PP_W    = GAIN_W + 1 + ERR_W;        // kp * error
    localparam int PI_W    = GAIN_W + 1 + INTEG_W;      // ki * integral
    localparam int PD_W    = GAIN_W + 1 + ERR_W + 1;    // kd * derivative
    localparam int ACC_W   = PI_W + 1;
    localparam int MAG_W   = ACC_W - 16;

    // Configuration registers.
    logic [GAIN_W-1:0]         kp_reg;
    logic [GAIN_W-1:0]         ki_reg;
    logic [GAIN_W-1:0]         kd_reg;
    logic signed [SPEED_W-1:0] base_reg;

    // Controller state.
    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [INTEG_W-1:0] integral_reg;

    // Pipeline valid bits and stage readiness.
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, out_rdy;
    logic s_fire;

    // Stage payloads.
    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [INTEG_W-1:0] integ1_reg;
    logic signed [ERR_W:0]     deriv1_reg;
    logic signed [PP_W-1:0]    pp2_reg;
    logic signed [PI_W-1:0]    pi2_reg;
    logic signed [PD_W-1:0]    pd2_reg;
    logic signed [ERR_W-1:0]   err2_reg;
    logic signed [ACC_W-1:0]   acc3_reg;
    logic signed [ERR_W-1:0]   err3_reg;
    logic signed [SPEED_W-1:0] drive4_reg;
    logic signed [ERR_W-1:0]   err4_reg;
    logic signed [SPEED_W-1:0] left_reg;
    logic signed [SPEED_W-1:0] right_reg;
    logic signed [SPEED_W-1:0] drive_reg;
    logic signed [ERR_W-1:0]   err_reg;

    // Decode and state update logic.
    logic signed [ERR_W-1:0]   err_next;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ERR_W:0]     deriv_next;
    logic                      is_clear;

    // Drive logic.
    logic [ACC_W-1:0]          acc_abs;
    logic [MAG_W-1:0]          mag;
    logic [SPEED_W-1:0]        mag_sat;
    logic signed [SPEED_W-1:0] drive_next;
    logic signed [SPEED_W:0]   lsum;
    logic signed [SPEED_W:0]   rsum;

    assign cfg_ready = 1'b1;

    // Each stage takes a beat when it is empty or its content moves on.
    assign out_rdy = !m_valid_reg || m_ready;
    assign rdy4    = !v4_reg || out_rdy;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign s_fire  = s_valid && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= lfps_pkg::KP_RESET;
            ki_reg   <= lfps_pkg::KI_RESET;
            kd_reg   <= lfps_pkg::KD_RESET;
            base_reg <= lfps_pkg::BASE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lfps_pkg::REG_KP_GAIN:    kp_reg   <= cfg_data;
                lfps_pkg::REG_KI_GAIN:    ki_reg   <= cfg_data;
                lfps_pkg::REG_KD_GAIN:    kd_reg   <= cfg_data;
                lfps_pkg::REG_BASE_SPEED: base_reg <= cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage one: decode the sensors and advance the state. A clear beat
    // forces every term to zero, so the rest of the pipeline needs no
    // special path for it.
    always_comb begin
        is_clear = (s_cmd == lfps_pkg::CMD_CLEAR);
        err_next = lfps_pkg::decode_error(s_sensor_bits, last_error_reg);
        isum     = {integral_reg[INTEG_W-1], integral_reg}
                 + {{(INTEG_W + 1 - ERR_W){err_next[ERR_W-1]}}, err_next};
        if (isum > lfps_pkg::INTEG_MAX) begin
            integ_next = lfps_pkg::INTEG_MAX[INTEG_W-1:0];
        end else if (isum < lfps_pkg::INTEG_MIN) begin
            integ_next = lfps_pkg::INTEG_MIN[INTEG_W-1:0];
        end else begin
            integ_next = isum[INTEG_W-1:0];
        end
        deriv_next = {err_next[ERR_W-1], err_next}
                   - {last_error_reg[ERR_W-1], last_error_reg};
        if (is_clear) begin
            err_next   = '0;
            integ_next = '0;
            deriv_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            integral_reg   <= '0;
        end else if (s_fire) begin
            last_error_reg <= err_next;
            integral_reg   <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            err1_reg   <= err_next;
            integ1_reg <= integ_next;
            deriv1_reg <= deriv_next;
        end
    end

    // Stage two: the three gain products, each at most 25 by 16 bits.
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            pp2_reg  <= $signed({1'b0, kp_reg}) * err1_reg;
            pi2_reg  <= $signed({1'b0, ki_reg}) * integ1_reg;
            pd2_reg  <= $signed({1'b0, kd_reg}) * deriv1_reg;
            err2_reg <= err1_reg;
        end
    end

    // Stage three: the Q16 sum of the three terms.
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            acc3_reg <= {{(ACC_W - PP_W){pp2_reg[PP_W-1]}}, pp2_reg}
                      + {{(ACC_W - PI_W){pi2_reg[PI_W-1]}}, pi2_reg}
                      + {{(ACC_W - PD_W){pd2_reg[PD_W-1]}}, pd2_reg};
            err3_reg <= err2_reg;
        end
    end

    // Stage four: drop the fraction toward zero, then clamp the magnitude.
    always_comb begin
        acc_abs = acc3_reg[ACC_W-1] ? (~acc3_reg + 1'b1) : acc3_reg;
        mag     = acc_abs[ACC_W-1:16];
        if (mag > MAG_W'(lfps_pkg::SPEED_LIMIT)) begin
            mag_sat = lfps_pkg::SPEED_LIMIT;
        end else begin
            mag_sat = mag[SPEED_W-1:0];
        end
        drive_next = acc3_reg[ACC_W-1] ? $signed(8'd0 - mag_sat) : $signed(mag_sat);
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            drive4_reg <= drive_next;
            err4_reg   <= err3_reg;
        end
    end

    // Output stage: mix the drive into the two motor setpoints.
    always_comb begin
        lsum = {base_reg[SPEED_W-1], base_reg} + {drive4_reg[SPEED_W-1], drive4_reg};
        rsum = {base_reg[SPEED_W-1], base_reg} - {drive4_reg[SPEED_W-1], drive4_reg};
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            left_reg  <= lfps_pkg::clamp_speed(lsum);
            right_reg <= lfps_pkg::clamp_speed(rsum);
            drive_reg <= drive4_reg;
            err_reg   <= err4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (out_rdy) begin
                m_valid_reg <= v4_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_speed     = left_reg;
    assign m_right_speed    = right_reg;
    assign m_drive          = drive_reg;
    assign m_position_error = err_reg;

endmodule

`default_nettype wire

[sv/lfps_checker.sv]
// Port-level checker for the line follower steering block, with its bind.
`default_nettype none

`include "line_follow_pid_steering_macros.svh"

module lfps_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                cfg_valid,
    input wire logic                                cfg_ready,
    input wire logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input wire logic [lfps_pkg::GAIN_W-1:0]         cfg_data,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                s_cmd,
    input wire logic [3:0]                          s_sensor_bits,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [lfps_pkg::SPEED_W-1:0] m_left_speed,
    input wire logic signed [lfps_pkg::SPEED_W-1:0] m_right_speed,
    input wire logic signed [lfps_pkg::SPEED_W-1:0] m_drive,
    input wire logic signed [lfps_pkg::ERR_W-1:0]   m_position_error
);

    logic in_range;
    logic unused_ok;

    assign in_range = (m_drive <= lfps_pkg::SPEED_LIMIT)
                   && (m_drive >= -lfps_pkg::SPEED_LIMIT)
                   && (m_left_speed <= lfps_pkg::SPEED_LIMIT)
                   && (m_left_speed >= -lfps_pkg::SPEED_LIMIT)
                   && (m_right_speed <= lfps_pkg::SPEED_LIMIT)
                   && (m_right_speed >= -lfps_pkg::SPEED_LIMIT);

    assign unused_ok = cfg_valid | cfg_ready | (|cfg_index) | (|cfg_data)
                     | s_valid | s_ready | s_cmd | (|s_sensor_bits);

    `LFPS_ASSERT_RST(a_no_result_after_reset, !m_valid, "result beat right after reset")

    `LFPS_ASSERT_NXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_drive) && $stable(m_left_speed) && $stable(m_right_speed) && $stable(m_position_error), "stalled result beat changed")

    `LFPS_ASSERT_IMP(a_speed_range, m_valid, in_range, "speed or drive outside the motor range")

    `LFPS_ASSERT_IMP(a_error_odd, m_valid && (m_position_error != 4'sd0), m_position_error[0] && (m_position_error != -4'sd8), "position error not a table value")

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the line follower PID steering block.
`timescale 1ns / 1ps

// The testbench drives sample and clear beats into the steering block,
// predicts every result beat with its own fixed-point model of the PID
// loop, and compares each result beat field by field against the oldest
// prediction. Both the sender and the receiver idle at random, with some
// stretches that run at full rate. The gains and the base speed are
// reloaded between phases, only while no beat is in flight.
module testbench;

    localparam int SPEED_W   = lfps_pkg::SPEED_W;
    localparam int ERR_W     = lfps_pkg::ERR_W;
    localparam int GAIN_W    = lfps_pkg::GAIN_W;
    localparam int CFG_IDX_W = lfps_pkg::CFG_IDX_W;

    // Integral saturation bound of the controller.
    localparam int INTEG_CAP = 32767;
    // Cycles to let pass after the last result before a register write.
    localparam int DRAIN_CYCLES = 12;
    // Number of random phases, each with its own register setting.
    localparam int RANDOM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 130;

    // Sensor patterns that decode to a defined error.
    localparam logic [3:0] LISTED [10] = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd8,
                                           4'd9, 4'd1, 4'd3, 4'd7, 4'd11};

    // One result beat as the block presents it.
    typedef struct packed {
        logic signed [SPEED_W-1:0] left_spd;
        logic signed [SPEED_W-1:0] right_spd;
        logic signed [SPEED_W-1:0] drive;
        logic signed [ERR_W-1:0]   pos_err;
    } steer_t;

    // One row of the directed sequence. Where typed is set, the row carries
    // its expected result; otherwise the predictor supplies it.
    typedef struct {
        logic       cmd;
        logic [3:0] bits;
        bit         typed;
        int         left_spd;
        int         right_spd;
        int         drive;
        int         pos_err;
    } row_t;

    // Directed sequence, run with the reset register values (proportional
    // gain 3.0, derivative gain 6.0, a tiny integral gain, base speed 40).
    // It covers every decoded pattern, the all-high pattern after a zero
    // and after a negative error, every pattern that keeps the old error,
    // and a clear in the middle of a run.
    row_t directed_rows [23] = '{
        '{lfps_pkg::CMD_CLEAR,  4'd15, 1'b1, 40,  40,  0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd9,  1'b1, 40,  40,  0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd0,  1'b1, 40,  40,  0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd15, 1'b1, 80, -23, 63, 7},
        '{lfps_pkg::CMD_SAMPLE, 4'd15, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd14, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd13, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd12, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd8,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd9,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd1,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd3,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd7,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd11, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd15, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd2,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd4,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd5,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd6,  1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd10, 1'b0, 0, 0, 0, 0},
        '{lfps_pkg::CMD_CLEAR,  4'd0,  1'b1, 40,  40,  0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd6,  1'b1, 40,  40,  0, 0},
        '{lfps_pkg::CMD_SAMPLE, 4'd15, 1'b1, 80, -23, 63, 7}
    };

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [GAIN_W-1:0]           cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_cmd;
    logic [3:0]                  s_sensor_bits;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [SPEED_W-1:0]   m_left_speed;
    logic signed [SPEED_W-1:0]   m_right_speed;
    logic signed [SPEED_W-1:0]   m_drive;
    logic signed [ERR_W-1:0]     m_position_error;

    // Shadow copy of the registers, as last written.
    logic [GAIN_W-1:0]           kp_q16 = lfps_pkg::KP_RESET;
    logic [GAIN_W-1:0]           ki_q16 = lfps_pkg::KI_RESET;
    logic [GAIN_W-1:0]           kd_q16 = lfps_pkg::KD_RESET;
    logic signed [SPEED_W-1:0]   base_spd = lfps_pkg::BASE_RESET;

    // Predicted controller state: the previous error and the integral.
    logic signed [ERR_W-1:0]     prev_err = '0;
    int                          integ_sum = 0;

    // Results predicted for accepted beats, oldest first.
    steer_t                      expected_steer [$];
    int                          mismatches = 0;
    // While set, neither side idles.
    bit                          calm = 1'b0;

    line_follow_pid_steering uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_sensor_bits    (s_sensor_bits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_speed     (m_left_speed),
        .m_right_speed    (m_right_speed),
        .m_drive          (m_drive),
        .m_position_error (m_position_error)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case a handshake never completes.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    // Maps a sensor pattern to the line position error. The all-high
    // pattern keeps the sign of the previous error at full magnitude, and
    // patterns outside the table keep the previous error.
    function automatic int line_error(input logic [3:0] bits,
                                      input logic signed [ERR_W-1:0] prev);
        case (bits)
            4'd15:   return (prev < 0) ? -7 : 7;
            4'd14:   return 5;
            4'd13:   return 5;
            4'd12:   return 3;
            4'd8:    return 1;
            4'd9:    return 0;
            4'd1:    return -1;
            4'd3:    return -3;
            4'd7:    return -5;
            4'd11:   return -5;
            default: return int'(prev);
        endcase
    endfunction

    function automatic logic signed [SPEED_W-1:0] clip_speed(input int v);
        if (v > int'(lfps_pkg::SPEED_LIMIT)) begin
            return lfps_pkg::SPEED_LIMIT;
        end
        if (v < -int'(lfps_pkg::SPEED_LIMIT)) begin
            return -lfps_pkg::SPEED_LIMIT;
        end
        return SPEED_W'(v);
    endfunction

    // Runs one controller step on the predicted state and returns the
    // result beat it should produce.
    function automatic steer_t compute_steering(input logic cmd, input logic [3:0] bits);
        steer_t res;
        int     err_now;
        int     integ_next;
        int     deriv;
        int     drv;
        int     mag;
        longint acc;
        if (cmd == lfps_pkg::CMD_CLEAR) begin
            err_now = 0;
            integ_next = 0;
            drv = 0;
        end else begin
            err_now = line_error(bits, prev_err);
            integ_next = integ_sum + err_now;
            if (integ_next > INTEG_CAP) begin
                integ_next = INTEG_CAP;
            end else if (integ_next < -INTEG_CAP) begin
                integ_next = -INTEG_CAP;
            end
            deriv = err_now - int'(prev_err);
            // Gains carry 16 fraction bits; the sum is exact and then
            // truncated toward zero, so the magnitude is shifted.
            acc = longint'(kp_q16) * err_now + longint'(ki_q16) * integ_next
                + longint'(kd_q16) * deriv;
            mag = (acc < 0) ? int'((-acc) >>> 16) : int'(acc >>> 16);
            drv = (mag > int'(lfps_pkg::SPEED_LIMIT)) ? int'(lfps_pkg::SPEED_LIMIT) : mag;
            if (acc < 0) begin
                drv = -drv;
            end
        end
        prev_err = ERR_W'(err_now);
        integ_sum = integ_next;
        res.drive = SPEED_W'(drv);
        res.pos_err = ERR_W'(err_now);
        res.left_spd = clip_speed(int'(base_spd) + drv);
        res.right_spd = clip_speed(int'(base_spd) - drv);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Sends one beat after a random gap and records what it should yield.
    // Valid is only lowered when a gap follows, so back-to-back beats keep
    // it high across the accepting edge.
    task automatic send_beat(input logic cmd, input logic [3:0] bits,
                             input bit typed, input steer_t typed_want);
        int     gap;
        steer_t want;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_sensor_bits <= bits;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = compute_steering(cmd, bits);
        if (typed) begin
            want = typed_want;
        end
        expected_steer.push_back(want);
    endtask

    // Waits until every predicted result has come back, then idles for the
    // drain time so that nothing is left inside the pipeline.
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_steer.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all four registers back to back and mirrors them.
    task automatic load_setting(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd,
                                input logic [GAIN_W-1:0] base_word);
        logic [GAIN_W-1:0]    word [4];
        logic [CFG_IDX_W-1:0] idx;
        word[lfps_pkg::REG_KP_GAIN] = kp;
        word[lfps_pkg::REG_KI_GAIN] = ki;
        word[lfps_pkg::REG_KD_GAIN] = kd;
        word[lfps_pkg::REG_BASE_SPEED] = base_word;
        for (int i = 0; i < 4; i++) begin
            idx = CFG_IDX_W'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= word[idx];
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            case (idx)
                lfps_pkg::REG_KP_GAIN:    kp_q16 = word[idx];
                lfps_pkg::REG_KI_GAIN:    ki_q16 = word[idx];
                lfps_pkg::REG_KD_GAIN:    kd_q16 = word[idx];
                lfps_pkg::REG_BASE_SPEED: base_spd = word[idx][SPEED_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: stalls a random number of cycles before each beat.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge aclk) begin : check_results
        steer_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_steer.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: drive %0d",
                                          m_drive));
            end else begin
                want = expected_steer.pop_front();
                if (m_left_speed !== want.left_spd) begin
                    report_mismatch($sformatf("left_speed got %0d expected %0d",
                                              m_left_speed, $signed(want.left_spd)));
                end
                if (m_right_speed !== want.right_spd) begin
                    report_mismatch($sformatf("right_speed got %0d expected %0d",
                                              m_right_speed, $signed(want.right_spd)));
                end
                if (m_drive !== want.drive) begin
                    report_mismatch($sformatf("drive got %0d expected %0d",
                                              m_drive, $signed(want.drive)));
                end
                if (m_position_error !== want.pos_err) begin
                    report_mismatch($sformatf("position_error got %0d expected %0d",
                                              m_position_error, $signed(want.pos_err)));
                end
            end
        end
    end

    initial begin : stimulus
        int                pick;
        int                beats;
        logic [3:0]        bits;
        logic [3:0]        prev_bits;
        logic [GAIN_W-1:0] gain [3];
        steer_t            want;

        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_cmd <= lfps_pkg::CMD_SAMPLE;
        s_sensor_bits <= '0;
        prev_bits = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sequence with the reset register values.
        foreach (directed_rows[i]) begin
            want.left_spd = SPEED_W'(directed_rows[i].left_spd);
            want.right_spd = SPEED_W'(directed_rows[i].right_spd);
            want.drive = SPEED_W'(directed_rows[i].drive);
            want.pos_err = ERR_W'(directed_rows[i].pos_err);
            send_beat(directed_rows[i].cmd, directed_rows[i].bits,
                      directed_rows[i].typed, want);
        end
        settle_idle();

        // Random phases. The first four pin the register extremes: every
        // gain at full scale with the largest base speed, every gain zero
        // with the most negative base speed, and the base speed exactly at
        // the clamp limits. Upper data bits on the base speed write are
        // junk on purpose, since only the low byte counts.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF7F);
                1: load_setting(24'h000000, 24'h000000, 24'h000000, 24'h000080);
                2: load_setting(24'h010000, 24'h000100, 24'h020000, 24'h5A00B0);
                3: load_setting(24'h028000, 24'h000200, 24'h040000, 24'hA50050);
                default: begin
                    // Mostly gains up to 8.0 (integral gain below 0.25) so the drive often
                    // stays inside its clamp, with an occasional full-range draw.
                    gain[0] = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom)
                                                          : GAIN_W'($urandom_range(0, 'h7FFFF));
                    gain[1] = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom)
                                                          : GAIN_W'($urandom_range(0, 'h3FFF));
                    gain[2] = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom)
                                                          : GAIN_W'($urandom_range(0, 'h7FFFF));
                    load_setting(gain[0], gain[1], gain[2], GAIN_W'($urandom));
                end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (beats = 0; beats < BEATS_PER_PHASE; beats++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    send_beat(lfps_pkg::CMD_CLEAR, 4'($urandom_range(0, 15)), 1'b0, '0);
                end else begin
                    // Mostly decoded patterns, some held patterns so the
                    // derivative goes to zero, and some raw noise.
                    if (pick < 15) begin
                        bits = 4'($urandom_range(0, 15));
                    end else if (pick < 35) begin
                        bits = prev_bits;
                    end else begin
                        bits = LISTED[$urandom_range(0, 9)];
                    end
                    send_beat(lfps_pkg::CMD_SAMPLE, bits, 1'b0, '0);
                    prev_bits = bits;
                end
            end
            settle_idle();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
